[rtl/cld_pkg.sv]
// ----------------------------------------------------------------------------
// cld_pkg
// Shared constants, codes and the link memory entry type for the cursor list.
// ----------------------------------------------------------------------------
package cld_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int LINK_W   = $clog2(MAX_ROWS + 1);

  // Link value that means no neighbour
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_ROWS);

  // Field and register widths
  localparam int MODE_W   = 3;
  localparam int STEP_W   = 10;
  localparam int QUERY_W  = 10;
  localparam int CURSOR_W = 10;
  localparam int STATUS_W = 3;
  localparam int RC_W     = 11;
  localparam int START_W  = 10;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Modes
  localparam logic [MODE_W-1:0] MODE_UP      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DOWN    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESTORE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_INIT    = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLIPPED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDO_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LAST_KEPT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_ROW    = 3'd4;

  // Register indexes (paddr[2])
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_START_CURSOR = 1'b1;

  typedef struct packed {
    logic              present;
    logic [LINK_W-1:0] prev_link;
    logic [LINK_W-1:0] next_link;
  } link_entry_t;

endpackage

[rtl/cursor_list_delete_undo.sv]
// ----------------------------------------------------------------------------
// cursor_list_delete_undo
// Row list with a cursor, delete and undo, kept in a link memory and a stack.
// ----------------------------------------------------------------------------
// Rows live in a doubly linked list held in one link memory (present bit,
// previous and next link per row); deleted rows go on an undo stack held in a
// second memory. One item is worked on at a time, and the result sits in an
// output register so the next item can be taken while it waits. Up and down
// read one link per row passed and stop early when an end is hit. Delete
// clears the row's present bit and relinks its neighbours; restore pops the
// undo stack, sets the present bit again and relinks; both skip a neighbour
// that is missing at either end of the list. Init writes every entry of the
// link memory, one per cycle.
// ----------------------------------------------------------------------------
module cursor_list_delete_undo (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [cld_pkg::MODE_W-1:0]      mode,
  input  logic [cld_pkg::STEP_W-1:0]      step_count,
  input  logic [cld_pkg::QUERY_W-1:0]     query_row,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [cld_pkg::CURSOR_W-1:0]    cursor_row,
  output logic                            row_present,
  output logic [cld_pkg::STATUS_W-1:0]    status,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cld_pkg::ADDR_W-1:0]      paddr,
  input  logic [cld_pkg::DATA_W-1:0]      pwdata,
  output logic [cld_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  import cld_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOVE  = 4'd1;
  localparam logic [3:0] S_DEL_A = 4'd2;
  localparam logic [3:0] S_DEL_P = 4'd3;
  localparam logic [3:0] S_DEL_N = 4'd4;
  localparam logic [3:0] S_RES_U = 4'd5;
  localparam logic [3:0] S_RES_A = 4'd6;
  localparam logic [3:0] S_RES_P = 4'd7;
  localparam logic [3:0] S_RES_N = 4'd8;
  localparam logic [3:0] S_QRY   = 4'd9;
  localparam logic [3:0] S_INIT  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]          state;
  logic [ROW_W-1:0]    cursor;
  logic [LINK_W-1:0]   live_rows;
  logic [LINK_W-1:0]   undo_depth;
  logic [RC_W-1:0]     row_count;
  logic [START_W-1:0]  start_cursor;

  logic [MODE_W-1:0]   op_mode;
  logic [STEP_W-1:0]   op_steps;
  logic [LINK_W-1:0]   p_link;
  logic [LINK_W-1:0]   n_link;
  logic [ROW_W-1:0]    r_row;
  logic [LINK_W-1:0]   sweep;
  logic [LINK_W-1:0]   init_n;
  logic [STATUS_W-1:0] res_status;
  logic                res_present;

  // memory ports
  logic                link_we;
  logic [ROW_W-1:0]    link_waddr;
  link_entry_t         link_wdata;
  logic [ROW_W-1:0]    link_raddr;
  link_entry_t         link_rdata;
  logic                undo_we;
  logic [ROW_W-1:0]    undo_waddr;
  logic [ROW_W-1:0]    undo_wdata;
  logic [ROW_W-1:0]    undo_raddr;
  logic [ROW_W-1:0]    undo_rdata;

  logic                cfg_write;
  logic [LINK_W-1:0]   move_link;
  logic                prev_ok;
  logic                next_ok;
  link_entry_t         init_entry;
  logic [LINK_W-1:0]   clamp_n;
  logic [LINK_W-1:0]   undo_dec;

  cld_ram #(
    .WIDTH ($bits(link_entry_t)),
    .DEPTH (MAX_ROWS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  cld_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_undo_ram (
    .clk   (clk),
    .we    (undo_we),
    .waddr (undo_waddr),
    .wdata (undo_wdata),
    .raddr (undo_raddr),
    .rdata (undo_rdata)
  );

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_ROW_COUNT:    prdata = DATA_W'(row_count);
      REG_START_CURSOR: prdata = DATA_W'(start_cursor);
      default:          prdata = '0;
    endcase
  end

  assign item_stall = (state != S_IDLE);

  assign move_link = (op_mode == MODE_DOWN) ? link_rdata.next_link : link_rdata.prev_link;
  assign prev_ok   = (link_rdata.prev_link < NO_LINK);
  assign next_ok   = (link_rdata.next_link < NO_LINK);
  assign undo_dec  = undo_depth - LINK_W'(1);

  // Row count zero links one row; too large saturates
  always_comb begin
    if (row_count == '0) begin
      clamp_n = LINK_W'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      clamp_n = NO_LINK;
    end else begin
      clamp_n = LINK_W'(row_count);
    end
  end

  always_comb begin
    init_entry.present   = (sweep < init_n);
    init_entry.prev_link = (sweep == '0 || sweep >= init_n) ? NO_LINK
                                                            : sweep - LINK_W'(1);
    init_entry.next_link = (sweep + LINK_W'(1) >= init_n) ? NO_LINK
                                                          : sweep + LINK_W'(1);
  end

  // Memory port steering
  always_comb begin
    link_raddr = cursor;
    link_we    = 1'b0;
    link_waddr = cursor;
    link_wdata = link_rdata;
    undo_we    = 1'b0;
    undo_waddr = undo_depth[ROW_W-1:0];
    undo_wdata = cursor;
    undo_raddr = undo_dec[ROW_W-1:0];
    case (state)
      S_IDLE: begin
        if (mode == MODE_QUERY) begin
          link_raddr = ROW_W'(query_row);
        end
      end
      S_MOVE: begin
        link_raddr = move_link[ROW_W-1:0];
      end
      S_DEL_A: begin
        link_we            = 1'b1;
        link_waddr         = cursor;
        link_wdata.present = 1'b0;
        undo_we            = 1'b1;
        link_raddr = prev_ok ? link_rdata.prev_link[ROW_W-1:0]
                             : link_rdata.next_link[ROW_W-1:0];
      end
      S_DEL_P: begin
        link_we              = 1'b1;
        link_waddr           = p_link[ROW_W-1:0];
        link_wdata.next_link = n_link;
        link_raddr           = n_link[ROW_W-1:0];
      end
      S_DEL_N: begin
        link_we              = 1'b1;
        link_waddr           = n_link[ROW_W-1:0];
        link_wdata.prev_link = p_link;
      end
      S_RES_U: begin
        link_raddr = undo_rdata;
      end
      S_RES_A: begin
        link_we            = 1'b1;
        link_waddr         = r_row;
        link_wdata.present = 1'b1;
        link_raddr = prev_ok ? link_rdata.prev_link[ROW_W-1:0]
                             : link_rdata.next_link[ROW_W-1:0];
      end
      S_RES_P: begin
        link_we              = 1'b1;
        link_waddr           = p_link[ROW_W-1:0];
        link_wdata.next_link = LINK_W'(r_row);
        link_raddr           = n_link[ROW_W-1:0];
      end
      S_RES_N: begin
        link_we              = 1'b1;
        link_waddr           = n_link[ROW_W-1:0];
        link_wdata.prev_link = LINK_W'(r_row);
      end
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = sweep[ROW_W-1:0];
        link_wdata = init_entry;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cursor       <= '0;
      live_rows    <= '0;
      undo_depth   <= '0;
      row_count    <= RC_W'(1024);
      start_cursor <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[2])
          REG_ROW_COUNT:    row_count    <= pwdata[RC_W-1:0];
          REG_START_CURSOR: start_cursor <= pwdata[START_W-1:0];
          default: begin
          end
        endcase
      end

      // The completion state reloads the output register itself
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            op_mode     <= mode;
            op_steps    <= step_count;
            res_present <= 1'b0;
            case (mode)
              MODE_UP, MODE_DOWN: begin
                if (live_rows == '0) begin
                  res_status <= (step_count != '0) ? ST_CLIPPED : ST_OK;
                  state      <= S_DONE;
                end else if (step_count == '0) begin
                  res_status <= ST_OK;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_MOVE;
                end
              end
              MODE_DELETE: begin
                if (live_rows <= LINK_W'(1) || undo_depth >= NO_LINK) begin
                  res_status <= ST_LAST_KEPT;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_DEL_A;
                end
              end
              MODE_RESTORE: begin
                if (undo_depth == '0) begin
                  res_status <= ST_UNDO_EMPTY;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  undo_depth <= undo_dec;
                  state      <= S_RES_U;
                end
              end
              MODE_QUERY: begin
                if (int'(query_row) >= MAX_ROWS) begin
                  res_status <= ST_BAD_ROW;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_QRY;
                end
              end
              MODE_INIT: begin
                res_status <= ST_OK;
                init_n     <= clamp_n;
                sweep      <= '0;
                state      <= S_INIT;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end

        // One link per cycle; stop at an end
        S_MOVE: begin
          if (move_link >= NO_LINK) begin
            res_status <= ST_CLIPPED;
            state      <= S_DONE;
          end else begin
            cursor   <= move_link[ROW_W-1:0];
            op_steps <= op_steps - STEP_W'(1);
            if (op_steps == STEP_W'(1)) begin
              state <= S_DONE;
            end
          end
        end

        S_DEL_A: begin
          p_link     <= link_rdata.prev_link;
          n_link     <= link_rdata.next_link;
          undo_depth <= undo_depth + LINK_W'(1);
          live_rows  <= live_rows - LINK_W'(1);
          cursor     <= next_ok ? link_rdata.next_link[ROW_W-1:0]
                                : link_rdata.prev_link[ROW_W-1:0];
          if (prev_ok) begin
            state <= S_DEL_P;
          end else if (next_ok) begin
            state <= S_DEL_N;
          end else begin
            state <= S_DONE;
          end
        end

        S_DEL_P: begin
          state <= (n_link < NO_LINK) ? S_DEL_N : S_DONE;
        end

        S_DEL_N: begin
          state <= S_DONE;
        end

        S_RES_U: begin
          if (int'(undo_rdata) >= MAX_ROWS) begin
            res_status <= ST_UNDO_EMPTY;
            state      <= S_DONE;
          end else begin
            r_row <= undo_rdata;
            state <= S_RES_A;
          end
        end

        S_RES_A: begin
          p_link    <= link_rdata.prev_link;
          n_link    <= link_rdata.next_link;
          live_rows <= live_rows + LINK_W'(1);
          if (prev_ok) begin
            state <= S_RES_P;
          end else if (next_ok) begin
            state <= S_RES_N;
          end else begin
            state <= S_DONE;
          end
        end

        S_RES_P: begin
          state <= (n_link < NO_LINK) ? S_RES_N : S_DONE;
        end

        S_RES_N: begin
          state <= S_DONE;
        end

        S_QRY: begin
          res_present <= link_rdata.present;
          state       <= S_DONE;
        end

        // Rewrite every entry, then place the cursor
        S_INIT: begin
          sweep <= sweep + LINK_W'(1);
          if (sweep == LINK_W'(MAX_ROWS - 1)) begin
            undo_depth <= '0;
            live_rows  <= init_n;
            if (int'(start_cursor) >= int'(init_n)) begin
              cursor     <= ROW_W'(init_n - LINK_W'(1));
              res_status <= ST_BAD_ROW;
            end else begin
              cursor <= ROW_W'(start_cursor);
            end
            state <= S_DONE;
          end
        end

        // Hold until the output register is free
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            cursor_row   <= CURSOR_W'(cursor);
            row_present  <= res_present;
            status       <= res_status;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Live rows plus undo depth never exceed the row capacity
  a_rows_bounded: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, undo_depth} + {1'b0, live_rows}) <= (LINK_W+1)'(MAX_ROWS))
    else $error("live rows plus undo depth exceed the row capacity");

  a_live_bounded: assert property (@(posedge clk) disable iff (rst)
    live_rows <= NO_LINK)
    else $error("live row count above capacity");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !(result_valid && result_stall))
      |=> (result_valid && state == S_IDLE))
    else $error("finished transaction not moved to the output register");

  a_init_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT && sweep == LINK_W'(MAX_ROWS - 1))
      |=> (undo_depth == '0 && live_rows == init_n && state == S_DONE))
    else $error("init sweep ended without resetting list counters");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the completion state");

endmodule

[rtl/cld_ram.sv]
// ----------------------------------------------------------------------------
// cld_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[verif/cursor_list_delete_undo_tb.sv]
// ----------------------------------------------------------------------------
// cursor_list_delete_undo_tb
// Self-checking bench for the cursor row list with delete and undo.
// ----------------------------------------------------------------------------
// A short table of directed items runs first: the block before any init, the
// ends of the list, delete at head and tail, and restore on an empty stack.
// Several phases follow. Each one sets the two registers over the APB port,
// reads them back, links a fresh list and sends random items. The idling
// pattern of both channels changes from phase to phase. Every result is
// compared field by field with its table row or a local copy of the list.
// ----------------------------------------------------------------------------
module cursor_list_delete_undo_tb;
  import cld_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 205;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1100;

  // Modes the block passes through untouched
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic [CURSOR_W-1:0] row;
    logic                present;
    logic [STATUS_W-1:0] code;
  } outcome_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [STEP_W-1:0]  steps;
    logic [QUERY_W-1:0] qrow;
    logic               typed;
    outcome_t           want;
  } script_row_t;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  logic [MODE_W-1:0]   mode;
  logic [STEP_W-1:0]   step_count;
  logic [QUERY_W-1:0]  query_row;
  logic                result_valid;
  logic                result_stall;
  logic [CURSOR_W-1:0] cursor_row;
  logic                row_present;
  logic [STATUS_W-1:0] status;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cursor_list_delete_undo u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .step_count   (step_count),
    .query_row    (query_row),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cursor_row   (cursor_row),
    .row_present  (row_present),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Local copy of the list
  logic [LINK_W-1:0]   prev_of   [MAX_ROWS];
  logic [LINK_W-1:0]   next_of   [MAX_ROWS];
  logic                live_bit  [MAX_ROWS];
  logic [ROW_W-1:0]    undo_rows [MAX_ROWS];
  int unsigned         undo_top;
  int unsigned         live_count;
  int unsigned         rows_linked;
  logic [ROW_W-1:0]    cur_row;
  int unsigned         cfg_rows;
  int unsigned         cfg_start;

  outcome_t            pending_outcomes [$];
  script_row_t         script [$];
  int unsigned         sender_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         errors;
  int unsigned         quiet_cycles;

  always #(CLK_HALF) clk = ~clk;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Apply one item to the local list and return the result it gives
  function automatic outcome_t list_apply(input logic [MODE_W-1:0] m,
                                          input logic [STEP_W-1:0] steps,
                                          input logic [QUERY_W-1:0] q);
    outcome_t    o;
    int unsigned n, k, p, nx, r;
    o = '0;
    case (m)
      MODE_UP, MODE_DOWN: begin
        if (live_count == 0) begin
          if (steps != 0) o.code = ST_CLIPPED;
        end else begin
          for (k = 0; k < steps && o.code == ST_OK; k++) begin
            nx = (m == MODE_DOWN) ? next_of[cur_row] : prev_of[cur_row];
            if (nx >= MAX_ROWS) o.code = ST_CLIPPED;
            else cur_row = ROW_W'(nx);
          end
        end
      end
      MODE_DELETE: begin
        if (live_count <= 1 || undo_top >= MAX_ROWS) begin
          o.code = ST_LAST_KEPT;
        end else begin
          p  = prev_of[cur_row];
          nx = next_of[cur_row];
          undo_rows[undo_top] = cur_row;
          undo_top++;
          live_bit[cur_row] = 1'b0;
          live_count--;
          if (p < MAX_ROWS) next_of[p] = LINK_W'(nx);
          if (nx < MAX_ROWS) prev_of[nx] = LINK_W'(p);
          // move to the following row, or back at the tail
          cur_row = (nx < MAX_ROWS) ? ROW_W'(nx) : ROW_W'(p);
        end
      end
      MODE_RESTORE: begin
        if (undo_top == 0) begin
          o.code = ST_UNDO_EMPTY;
        end else begin
          undo_top--;
          r  = undo_rows[undo_top];
          p  = prev_of[r];
          nx = next_of[r];
          if (p < MAX_ROWS) next_of[p] = LINK_W'(r);
          if (nx < MAX_ROWS) prev_of[nx] = LINK_W'(r);
          live_bit[r] = 1'b1;
          live_count++;
        end
      end
      MODE_QUERY: o.present = live_bit[q];
      MODE_INIT: begin
        n = cfg_rows;
        if (n == 0) n = 1;
        if (n > MAX_ROWS) n = MAX_ROWS;
        for (k = 0; k < MAX_ROWS; k++) begin
          live_bit[k] = (k < n);
          prev_of[k]  = (k == 0 || k >= n) ? NO_LINK : LINK_W'(k - 1);
          next_of[k]  = (k + 1 >= n) ? NO_LINK : LINK_W'(k + 1);
        end
        undo_top    = 0;
        live_count  = n;
        rows_linked = n;
        if (cfg_start >= n) begin
          cur_row = ROW_W'(n - 1);
          o.code  = ST_BAD_ROW;
        end else begin
          cur_row = ROW_W'(cfg_start);
        end
      end
      default: ;
    endcase
    o.row = cur_row;
    return o;
  endfunction

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_check(input logic [ADDR_W-1:0] addr, input int unsigned want,
                           input string what);
    logic [DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (got != want) report_mismatch(what, got, want);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one item, hold it until taken, then record its expected result
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [STEP_W-1:0] s,
                           input logic [QUERY_W-1:0] q, input logic typed,
                           input outcome_t typed_want);
    outcome_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    mode       <= m;
    step_count <= s;
    query_row  <= q;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = list_apply(m, s, q);
    pending_outcomes = {pending_outcomes, (typed ? typed_want : predicted)};
  endtask

  task automatic random_item();
    int unsigned        pick;
    int unsigned        spread;
    logic [MODE_W-1:0]  m;
    logic [STEP_W-1:0]  s;
    logic [QUERY_W-1:0] q;
    pick   = $urandom_range(99);
    spread = $urandom_range(9);
    // keep most walks short; a long one reads a link for every row it passes
    if (spread < 7) s = STEP_W'($urandom_range(7));
    else if (spread < 9) s = STEP_W'($urandom_range(63));
    else s = STEP_W'($urandom_range(1023));
    if ($urandom_range(1) && rows_linked != 0) q = QUERY_W'($urandom_range(rows_linked - 1));
    else q = QUERY_W'($urandom_range(1023));
    if (pick < 22) m = MODE_UP;
    else if (pick < 44) m = MODE_DOWN;
    else if (pick < 64) m = MODE_DELETE;
    else if (pick < 80) m = MODE_RESTORE;
    else if (pick < 93) m = (live_count != 0) ? MODE_QUERY : MODE_DOWN;
    else if (pick < 97) m = MODE_INIT;
    else m = $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
    send_item(m, s, q, 1'b0, '0);
  endtask

  // Drop valid and wait for every outstanding transaction to come back
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_step(input logic [MODE_W-1:0] m, input int unsigned s,
                          input int unsigned q, input logic typed,
                          input int unsigned row, input logic present,
                          input logic [STATUS_W-1:0] code);
    script_row_t e;
    e.mode         = m;
    e.steps        = STEP_W'(s);
    e.qrow         = QUERY_W'(q);
    e.typed        = typed;
    e.want.row     = CURSOR_W'(row);
    e.want.present = present;
    e.want.code    = code;
    script = {script, e};
  endtask

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing pending, cursor_row", cursor_row, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (cursor_row != want.row) report_mismatch("cursor_row", cursor_row, want.row);
        if (row_present != want.present)
          report_mismatch("row_present", row_present, want.present);
        if (status != want.code) report_mismatch("status", status, want.code);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_outcomes.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned rows;
    int unsigned start;
    clk          = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    mode         = MODE_UP;
    step_count   = '0;
    query_row    = '0;
    result_stall = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    errors       = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      prev_of[i]   = '0;
      next_of[i]   = '0;
      live_bit[i]  = 1'b0;
      undo_rows[i] = '0;
    end
    undo_top    = 0;
    live_count  = 0;
    rows_linked = 0;
    cur_row     = '0;
    cfg_rows    = 1024;
    cfg_start   = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_check({REG_ROW_COUNT, 2'b00}, cfg_rows, "row_count after reset");
    cfg_check({REG_START_CURSOR, 2'b00}, cfg_start, "start_cursor after reset");

    // Nothing linked yet: nonzero moves clip, delete and restore are refused
    add_step(MODE_UP,      0,    0,    1'b1, 0,    1'b0, ST_OK);
    add_step(MODE_UP,      1023, 0,    1'b1, 0,    1'b0, ST_CLIPPED);
    add_step(MODE_DOWN,    1,    0,    1'b1, 0,    1'b0, ST_CLIPPED);
    add_step(MODE_DELETE,  0,    0,    1'b1, 0,    1'b0, ST_LAST_KEPT);
    add_step(MODE_RESTORE, 0,    0,    1'b1, 0,    1'b0, ST_UNDO_EMPTY);
    add_step(MODE_SPARE6,  0,    0,    1'b1, 0,    1'b0, ST_OK);
    add_step(MODE_SPARE7,  1023, 1023, 1'b1, 0,    1'b0, ST_OK);
    // Full list of 1024 rows, cursor on row 0
    add_step(MODE_INIT,    0,    0,    1'b1, 0,    1'b0, ST_OK);
    add_step(MODE_QUERY,   0,    1023, 1'b1, 0,    1'b1, ST_OK);
    add_step(MODE_UP,      1,    0,    1'b1, 0,    1'b0, ST_CLIPPED);
    add_step(MODE_DOWN,    1023, 0,    1'b1, 1023, 1'b0, ST_OK);
    add_step(MODE_DOWN,    1,    0,    1'b1, 1023, 1'b0, ST_CLIPPED);
    // Delete at the tail steps back
    add_step(MODE_DELETE,  0,    0,    1'b1, 1022, 1'b0, ST_OK);
    add_step(MODE_QUERY,   0,    1023, 1'b1, 1022, 1'b0, ST_OK);
    add_step(MODE_RESTORE, 0,    0,    1'b1, 1022, 1'b0, ST_OK);
    add_step(MODE_QUERY,   0,    1023, 1'b1, 1022, 1'b1, ST_OK);
    add_step(MODE_RESTORE, 0,    0,    1'b1, 1022, 1'b0, ST_UNDO_EMPTY);
    add_step(MODE_UP,      1023, 0,    1'b1, 0,    1'b0, ST_CLIPPED);
    // Delete at the head steps forward
    add_step(MODE_DELETE,  0,    0,    1'b1, 1,    1'b0, ST_OK);
    add_step(MODE_QUERY,   0,    0,    1'b1, 1,    1'b0, ST_OK);
    add_step(MODE_DOWN,    5,    0,    1'b0, 0,    1'b0, ST_OK);
    add_step(MODE_DELETE,  0,    0,    1'b0, 0,    1'b0, ST_OK);
    add_step(MODE_RESTORE, 0,    0,    1'b0, 0,    1'b0, ST_OK);
    add_step(MODE_UP,      1,    0,    1'b0, 0,    1'b0, ST_OK);
    add_step(MODE_RESTORE, 0,    0,    1'b0, 0,    1'b0, ST_OK);
    foreach (script[i]) send_item(script[i].mode, script[i].steps, script[i].qrow,
                                  script[i].typed, script[i].want);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin sender_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // zero rows links one; 2047 saturates; some starts lie past the end
      case (ph)
        0: begin rows = 0;    start = 0;    end
        1: begin rows = 1;    start = 1023; end
        2: begin rows = 2047; start = 1023; end
        3: begin rows = 5;    start = 2;    end
        4: begin rows = 17;   start = 16;   end
        5: begin rows = 1024; start = 512;  end
        6: begin rows = 3;    start = 3;    end
        default: begin rows = $urandom_range(64, 1); start = $urandom_range(63); end
      endcase
      cfg_write({REG_ROW_COUNT, 2'b00}, rows);
      cfg_rows = rows;
      cfg_write({REG_START_CURSOR, 2'b00}, start);
      cfg_start = start;
      cfg_check({REG_ROW_COUNT, 2'b00}, rows, "row_count");
      cfg_check({REG_START_CURSOR, 2'b00}, start, "start_cursor");
      send_item(MODE_INIT, STEP_W'($urandom_range(1023)), QUERY_W'($urandom_range(1023)),
                1'b0, '0);
      repeat (PHASE_ITEMS) random_item();
      wait_idle();
    end

    // Catch any stray result after the last one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cld_pkg.sv
rtl/cld_ram.sv
rtl/cursor_list_delete_undo.sv
verif/cursor_list_delete_undo_tb.sv
